// ===== rtl/ads_pkg.sv =====
// ----------------------------------------------------------------------------
// ads_pkg
// Types, codes and helpers shared by the ATA disk command sequencer.
// ----------------------------------------------------------------------------
package ads_pkg;

  // Largest data block, in sectors.
  localparam int unsigned MaxBlockSectors = 32;
  // Entries in the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // ATA command bytes
  localparam logic [7:0] CmdIdentify       = 8'hEC;
  localparam logic [7:0] CmdReadSectors    = 8'h20;
  localparam logic [7:0] CmdReadSectorsNr  = 8'h21;
  localparam logic [7:0] CmdReadMultiple   = 8'hC4;
  localparam logic [7:0] CmdWriteSectors   = 8'h30;
  localparam logic [7:0] CmdWriteSectorsNr = 8'h31;
  localparam logic [7:0] CmdWriteMultiple  = 8'hC5;
  localparam logic [7:0] CmdSetMultiple    = 8'hC6;

  // Cylinder signature of an absent drive
  localparam logic [15:0] CylAbsent = 16'hFFFF;

  // Status bits
  localparam logic [7:0] StBsy = 8'h80;
  localparam logic [7:0] StRdy = 8'h40;
  localparam logic [7:0] StSkc = 8'h10;
  localparam logic [7:0] StDrq = 8'h08;
  localparam logic [7:0] StIrq = 8'h04;
  localparam logic [7:0] StErr = 8'h01;

  // Full status bytes as reported (SKC added unless BSY or ERR)
  localparam logic [7:0] StatBusy    = StBsy;
  localparam logic [7:0] StatReady   = StRdy | StSkc;
  localparam logic [7:0] StatAbort   = StRdy | StErr | StIrq;
  localparam logic [7:0] StatDrq     = StRdy | StSkc | StDrq;
  localparam logic [7:0] StatDrqIrq  = StRdy | StSkc | StDrq | StIrq;

  localparam logic [7:0] ErrAbort = 8'h04;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_CMD   = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_RESET = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    XFER_NONE  = 2'd0,
    XFER_READ  = 2'd1,
    XFER_WRITE = 2'd2,
    XFER_IDENT = 2'd3
  } xfer_e;

  typedef enum logic [2:0] {
    PH_RESET    = 3'd0,
    PH_IDLE     = 3'd1,
    PH_WAIT_RD  = 3'd2,
    PH_WAIT_WR  = 3'd3,
    PH_WAIT_END = 3'd4
  } phase_e;

  // Classified event handed from the front to the back
  typedef enum logic [2:0] {
    ACT_TICK,
    ACT_RESET,
    ACT_ABORT,
    ACT_IDENT,
    ACT_READ,
    ACT_WRITE,
    ACT_SETMULT,
    ACT_DATA
  } action_e;

  typedef struct packed {
    logic [7:0]  count;
    logic [7:0]  sector;
    logic [15:0] cylinder;
    logic [3:0]  head;
    logic        drive;
    logic        lba;
  } taskfile_t;

  typedef struct packed {
    action_e   act;
    taskfile_t tf;
  } action_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  command_code;
    logic [7:0]  count_in;
    logic [7:0]  sector_in;
    logic [15:0] cylinder_in;
    logic [3:0]  head_in;
    logic        drive_in;
    logic        lba_in;
  } event_t;

  typedef struct packed {
    logic [7:0]  status_out;
    logic [7:0]  error_out;
    logic [7:0]  count_out;
    logic [7:0]  sector_out;
    logic [15:0] cylinder_out;
    logic [3:0]  head_out;
    logic        drive_out;
    logic        lba_out;
    logic [5:0]  block_size;
    xfer_e       transfer_op;
    logic [27:0] transfer_lba;
    logic [5:0]  transfer_count;
  } result_t;

  // Sectors in one block for a given remaining count
  function automatic logic [7:0] block_of(input logic [7:0] cnt);
    logic [7:0] max_blk;
    max_blk = 8'(MaxBlockSectors);
    if (cnt == 8'd0 || cnt > max_blk) begin
      return max_blk;
    end
    return cnt;
  endfunction

endpackage

// ===== rtl/ads_chan_if.sv =====
// ----------------------------------------------------------------------------
// ads_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface ads_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ads_front.sv =====
// ----------------------------------------------------------------------------
// ads_front
// Holds the drive-present mask and classifies incoming events.
// ----------------------------------------------------------------------------
module ads_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  ads_chan_if.sink     in_i,
  ads_chan_if.sink     cfg_i,
  ads_chan_if.source   push_o
);

  logic [1:0]       mask_q;
  logic [1:0]       mask_d;
  ads_pkg::event_t  ev;
  ads_pkg::action_t act;
  logic             present;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    mask_d = mask_q;
    if (cfg_i.valid) begin
      mask_d = cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  assign ev      = in_i.data;
  assign present = mask_q[ev.drive_in];

  always_comb begin
    act.tf.count    = ev.count_in;
    act.tf.sector   = ev.sector_in;
    act.tf.cylinder = ev.cylinder_in;
    act.tf.head     = ev.head_in;
    act.tf.drive    = ev.drive_in;
    act.tf.lba      = ev.lba_in;
    act.act         = ads_pkg::ACT_ABORT;
    unique case (ev.kind)
      ads_pkg::KIND_TICK: act.act = ads_pkg::ACT_TICK;
      ads_pkg::KIND_DATA: act.act = ads_pkg::ACT_DATA;
      ads_pkg::KIND_RESET: begin
        act.act         = ads_pkg::ACT_RESET;
        act.tf.head     = '0;
        act.tf.sector   = 8'd1;
        act.tf.count    = 8'd1;
        act.tf.cylinder = present ? 16'd0 : ads_pkg::CylAbsent;
      end
      ads_pkg::KIND_CMD: begin
        if (present) begin
          unique case (ev.command_code) inside
            ads_pkg::CmdIdentify: begin
              act.act         = ads_pkg::ACT_IDENT;
              act.tf.count    = '0;
              act.tf.sector   = '0;
              act.tf.cylinder = '0;
              act.tf.head     = '0;
              act.tf.lba      = 1'b0;
            end
            ads_pkg::CmdReadSectors, ads_pkg::CmdReadSectorsNr,
            ads_pkg::CmdReadMultiple: begin
              if (ev.lba_in) act.act = ads_pkg::ACT_READ;
            end
            ads_pkg::CmdWriteSectors, ads_pkg::CmdWriteSectorsNr,
            ads_pkg::CmdWriteMultiple: begin
              if (ev.lba_in) act.act = ads_pkg::ACT_WRITE;
            end
            ads_pkg::CmdSetMultiple: begin
              if (ev.count_in != 8'd0 &&
                  ev.count_in <= 8'(ads_pkg::MaxBlockSectors)) begin
                act.act = ads_pkg::ACT_SETMULT;
              end
            end
            default: act.act = ads_pkg::ACT_ABORT;
          endcase
        end
      end
      default: act.act = ads_pkg::ACT_ABORT;
    endcase
  end

  assign push_o.valid = in_i.valid;
  assign push_o.data  = act;
  assign in_i.ready   = push_o.ready;

endmodule

// ===== rtl/ads_queue.sv =====
// ----------------------------------------------------------------------------
// ads_queue
// Short register queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module ads_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  ads_chan_if.sink   push_i,
  ads_chan_if.source pop_o
);

  localparam int unsigned Depth = ads_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ads_pkg::action_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_i.ready = (cnt_q != FullCnt);
  assign pop_o.valid  = (cnt_q != '0);
  assign pop_o.data   = mem_q[rd_ptr_q];

  assign push = push_i.valid && push_i.ready;
  assign pop  = pop_o.valid && pop_o.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == FullCnt) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/ads_back.sv =====
// ----------------------------------------------------------------------------
// ads_back
// Sequencer state, task file update and the registered result stage.
// ----------------------------------------------------------------------------
module ads_back (
  input  logic       clk_i,
  input  logic       rst_ni,
  ads_chan_if.sink   pop_i,
  ads_chan_if.source out_o
);

  ads_pkg::phase_e    phase_q, phase_d;
  ads_pkg::taskfile_t tf_q, tf_d;
  logic [7:0]         pend_q, pend_d;
  logic [7:0]         block_q, block_d;
  logic               out_valid_q, out_valid_d;
  ads_pkg::result_t   out_q, res;

  ads_pkg::action_t   ent;
  ads_pkg::taskfile_t base;
  logic               load, use_pend, fire, emit;
  logic [27:0]        start, sum;
  logic [7:0]         cnt, new_count;
  logic [7:0]         status;
  logic [7:0]         err;
  ads_pkg::xfer_e     op;
  logic [27:0]        tlba;
  logic [7:0]         tcnt;

  assign ent  = pop_i.data;
  assign load = (ent.act != ads_pkg::ACT_TICK) && (ent.act != ads_pkg::ACT_DATA);
  assign base = load ? ent.tf : tf_q;

  // One block transfer: start LBA, sectors, and the task file after it
  assign use_pend  = (ent.act == ads_pkg::ACT_DATA) && (phase_q == ads_pkg::PH_WAIT_WR);
  assign start     = {base.head, base.cylinder, base.sector};
  assign cnt       = use_pend ? pend_q : ads_pkg::block_of(base.count);
  assign sum       = start + 28'(cnt);
  assign new_count = base.count - cnt;

  assign pop_i.ready = !out_valid_q || out_o.ready;
  assign fire        = pop_i.valid && pop_i.ready;

  always_comb begin
    phase_d = phase_q;
    tf_d    = base;
    pend_d  = pend_q;
    block_d = block_q;
    emit    = 1'b1;
    status  = ads_pkg::StatReady;
    err     = '0;
    op      = ads_pkg::XFER_NONE;
    tlba    = '0;
    tcnt    = '0;
    unique case (ent.act)
      ads_pkg::ACT_TICK: begin
        emit = (phase_q == ads_pkg::PH_RESET);
        if (emit) phase_d = ads_pkg::PH_IDLE;
      end
      ads_pkg::ACT_RESET: begin
        phase_d = ads_pkg::PH_RESET;
        status  = ads_pkg::StatBusy;
      end
      ads_pkg::ACT_ABORT: begin
        phase_d = ads_pkg::PH_IDLE;
        status  = ads_pkg::StatAbort;
        err     = ads_pkg::ErrAbort;
      end
      ads_pkg::ACT_IDENT: begin
        block_d = 8'd1;
        phase_d = ads_pkg::PH_WAIT_END;
        status  = ads_pkg::StatDrqIrq;
        op      = ads_pkg::XFER_IDENT;
        tcnt    = 8'd1;
      end
      ads_pkg::ACT_WRITE: begin
        pend_d  = cnt;
        block_d = cnt;
        phase_d = ads_pkg::PH_WAIT_WR;
        status  = ads_pkg::StatDrq;
      end
      ads_pkg::ACT_SETMULT: begin
        phase_d = ads_pkg::PH_IDLE;
      end
      ads_pkg::ACT_READ, ads_pkg::ACT_DATA: begin
        if (ent.act == ads_pkg::ACT_READ || phase_q == ads_pkg::PH_WAIT_RD) begin
          tf_d.sector   = sum[7:0];
          tf_d.cylinder = sum[23:8];
          tf_d.head     = sum[27:24];
          tf_d.count    = new_count;
          block_d       = cnt;
          phase_d       = (new_count != 8'd0) ? ads_pkg::PH_WAIT_RD : ads_pkg::PH_WAIT_END;
          status        = ads_pkg::StatDrqIrq;
          op            = ads_pkg::XFER_READ;
          tlba          = start;
          tcnt          = cnt;
        end else begin
          unique case (phase_q)
            ads_pkg::PH_WAIT_END: begin
              phase_d = ads_pkg::PH_IDLE;
            end
            ads_pkg::PH_WAIT_WR: begin
              tf_d.sector   = sum[7:0];
              tf_d.cylinder = sum[23:8];
              tf_d.head     = sum[27:24];
              tf_d.count    = new_count;
              op            = ads_pkg::XFER_WRITE;
              tlba          = start;
              tcnt          = cnt;
              if (new_count != 8'd0) begin
                pend_d  = ads_pkg::block_of(new_count);
                block_d = ads_pkg::block_of(new_count);
                status  = ads_pkg::StatDrqIrq;
              end else begin
                phase_d = ads_pkg::PH_IDLE;
              end
            end
            default: begin
              // data request with nothing pending
              phase_d = ads_pkg::PH_IDLE;
              status  = ads_pkg::StatAbort;
              err     = ads_pkg::ErrAbort;
            end
          endcase
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    res.status_out     = status;
    res.error_out      = err;
    res.count_out      = tf_d.count;
    res.sector_out     = tf_d.sector;
    res.cylinder_out   = tf_d.cylinder;
    res.head_out       = tf_d.head;
    res.drive_out      = tf_d.drive;
    res.lba_out        = tf_d.lba;
    res.block_size     = block_d[5:0];
    res.transfer_op    = op;
    res.transfer_lba   = tlba;
    res.transfer_count = tcnt[5:0];
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (fire && emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ads_pkg::PH_RESET;
      tf_q        <= '0;
      pend_q      <= '0;
      block_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        phase_q <= phase_d;
        tf_q    <= tf_d;
        pend_q  <= pend_d;
        block_q <= block_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_rd_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ads_pkg::PH_WAIT_RD |-> tf_q.count != 8'd0)
    else $error("read pending with zero count");

  a_wr_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ads_pkg::PH_WAIT_WR |-> (pend_q != 8'd0 && pend_q == block_q))
    else $error("write pending without a valid block");

  a_block_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_q <= 8'(ads_pkg::MaxBlockSectors))
    else $error("block larger than the maximum");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !fire)
    else $error("new beat taken while result stalled");

endmodule

// ===== rtl/ata_disk_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// ata_disk_command_sequencer
// Disk side of an ATA task-file device: classifies host events and runs
// identify, LBA read/write and set-multiple, reporting transfers per block.
// ----------------------------------------------------------------------------
//   channel  dir  payload             beat when
//   in_i     in   ads_pkg::event_t    valid && ready
//   out_o    out  ads_pkg::result_t   valid && ready
//   cfg_i    in   drive-present mask  valid && ready (ready always high)
//
// One event per cycle sustained while out_o is ready; after its event beat a
// result is registered in the queue, then in the executor's output register.
// Idle ticks outside the reset phase give no result.
// Reset clears the mask, the sequencer phase and the task file at once.
// A stalled output holds the executor; the two-entry queue then fills and
// in_i.ready falls.
// ----------------------------------------------------------------------------
module ata_disk_command_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  ads_chan_if.sink   in_i,
  ads_chan_if.source out_o,
  ads_chan_if.sink   cfg_i
);

  ads_chan_if #(.payload_t(ads_pkg::action_t)) push_ch ();
  ads_chan_if #(.payload_t(ads_pkg::action_t)) pop_ch ();

  ads_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .push_o (push_ch)
  );

  ads_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_ch),
    .pop_o  (pop_ch)
  );

  ads_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pop_i  (pop_ch),
    .out_o  (out_o)
  );

endmodule
